### src/gcsp_pkg.sv
`timescale 1ns / 1ps

package gcsp_pkg;

  localparam int SLOT_COUNT_DEF = 2048;
  localparam int CP_W           = 21;
  localparam int COORD_W        = 12;
  localparam int SIZE_W         = 13;
  localparam int ROW_W          = 14;
  localparam int PAD_W          = 4;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 13;
  localparam int ENTRY_SLOT_W   = 11;
  localparam int ALU_W          = 16;
  localparam int TAG_W          = CP_W + 1;
  localparam int PROD_W         = CP_W + 32;

  localparam logic [31:0]       HASH_MUL   = 32'd2654435761;
  localparam int                HASH_SHIFT = 29;
  localparam logic [ALU_W-1:0]  ROW_MAX    = ALU_W'(16383);

  localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_PIXELS   = 2'd2;

  localparam logic [SIZE_W-1:0] ATLAS_WIDTH_RST  = 13'd1024;
  localparam logic [SIZE_W-1:0] ATLAS_HEIGHT_RST = 13'd1024;
  localparam logic [PAD_W-1:0]  PAD_PIXELS_RST   = 4'd1;
  localparam logic [SIZE_W-1:0] SHELF_COL_RST    = 13'd2;
  localparam logic [SIZE_W-1:0] SHELF_TALL_RST   = 13'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_PROBE,
    ST_WRAP,
    ST_ROW,
    ST_FIT,
    ST_COL,
    ST_TALL
  } st_t;

  typedef struct packed {
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [COORD_W-1:0] size_w;
    logic [COORD_W-1:0] size_h;
    logic [COORD_W-1:0] bear_x;
    logic [COORD_W-1:0] bear_y;
  } entry_t;

  typedef struct packed {
    logic                    hit;
    logic                    drawable;
    logic                    atlas_full;
    logic                    table_full;
    logic [ENTRY_SLOT_W-1:0] slot;
    entry_t                  ent;
  } result_t;

  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic [ALU_W-1:0] c;
    logic [ALU_W-1:0] lim;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] sum;
    logic             gt;
  } alu_rsp_t;

endpackage

### src/gcsp_hash.sv
`timescale 1ns / 1ps

module gcsp_hash #(
  parameter int SLOT_COUNT = gcsp_pkg::SLOT_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          load,
  input  logic [gcsp_pkg::CP_W-1:0]     cp,
  output logic [$clog2(SLOT_COUNT)-1:0] slot
);
  import gcsp_pkg::*;

  localparam int SLOT_W = $clog2(SLOT_COUNT);

  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] mixed;

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= PROD_W'(cp) * PROD_W'(HASH_MUL);
    end
  end

  assign mixed = prod_r ^ (prod_r >> HASH_SHIFT);
  assign slot  = mixed[SLOT_W-1:0];

endmodule

### src/gcsp_alu.sv
`timescale 1ns / 1ps

module gcsp_alu (
  input  gcsp_pkg::alu_req_t req,
  output gcsp_pkg::alu_rsp_t rsp
);
  import gcsp_pkg::*;

  logic [ALU_W-1:0] sum;

  assign sum     = req.a + req.b + req.c;
  assign rsp.sum = sum;
  assign rsp.gt  = sum > req.lim;

endmodule

### src/glyph_cache_shelf_packer_core.sv
`timescale 1ns / 1ps

// Glyph cache with shelf packing. After reset the block runs a clearing pass over every slot
// of the table, with busy high; configuration writes are taken meanwhile. A request is
// taken when start is high and busy is low. The table is probed one slot per cycle through
// single registered read ports on its tag and payload arrays. A placed miss then runs its
// shelf arithmetic one step a cycle on one shared adder and comparator: the wrap check, a
// new row when the shelf wraps, the fit check, then the column and shelf height updates.
// Each result appears for exactly one cycle with out_valid; the receiver cannot stall it,
// so it must take every result as it comes.
module glyph_cache_shelf_packer_core #(
  parameter int SLOT_COUNT = gcsp_pkg::SLOT_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [gcsp_pkg::CP_W-1:0]           in_code_point,
  input  logic signed [gcsp_pkg::COORD_W-1:0] in_box_left,
  input  logic signed [gcsp_pkg::COORD_W-1:0] in_box_top,
  input  logic signed [gcsp_pkg::COORD_W-1:0] in_box_right,
  input  logic signed [gcsp_pkg::COORD_W-1:0] in_box_bottom,
  input  logic                                cfg_we,
  input  logic [gcsp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gcsp_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                out_valid,
  output logic                                out_hit,
  output logic                                out_drawable,
  output logic                                out_atlas_full,
  output logic                                out_table_full,
  output logic [gcsp_pkg::ENTRY_SLOT_W-1:0]   out_entry_slot,
  output logic [gcsp_pkg::COORD_W-1:0]        out_atlas_x,
  output logic [gcsp_pkg::COORD_W-1:0]        out_atlas_y,
  output logic [gcsp_pkg::COORD_W-1:0]        out_glyph_width,
  output logic [gcsp_pkg::COORD_W-1:0]        out_glyph_height,
  output logic signed [gcsp_pkg::COORD_W-1:0] out_bearing_x,
  output logic signed [gcsp_pkg::COORD_W-1:0] out_bearing_y
);
  import gcsp_pkg::*;

  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int CNT_W  = SLOT_W + 1;

  st_t state_r, state_nxt;

  logic [SLOT_W-1:0] probe_addr_r, probe_addr_nxt;
  logic [CNT_W-1:0]  probe_cnt_r, probe_cnt_nxt;
  logic [SLOT_W-1:0] hash_slot;

  logic [TAG_W-1:0] tag_mem [SLOT_COUNT];
  logic [TAG_W-1:0] tag_q_r;
  logic             tag_we;
  logic [TAG_W-1:0] tag_wdata;

  entry_t pay_mem [SLOT_COUNT];
  entry_t pay_q_r;
  logic   pay_we;
  entry_t pay_wdata;

  logic [CP_W-1:0]    cp_r;
  logic [COORD_W-1:0] left_r, top_r;
  logic [SIZE_W-1:0]  w_r, h_r;
  logic [SIZE_W-1:0]  box_w, box_h;
  logic               box_empty;

  logic [SIZE_W-1:0] width_r, height_r;
  logic [PAD_W-1:0]  pad_r;

  logic [SIZE_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [SIZE_W-1:0] tall_r, tall_nxt;

  result_t res_r, res_nxt;
  logic    out_valid_r, out_valid_nxt;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;
  entry_t   placed;
  logic     accept;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);

  gcsp_hash #(.SLOT_COUNT(SLOT_COUNT)) u_hash (
    .clk  (clk),
    .load (accept),
    .cp   (in_code_point),
    .slot (hash_slot)
  );

  gcsp_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign box_w     = {in_box_right[COORD_W-1], in_box_right}
                   - {in_box_left[COORD_W-1], in_box_left};
  assign box_h     = {in_box_bottom[COORD_W-1], in_box_bottom}
                   - {in_box_top[COORD_W-1], in_box_top};
  assign box_empty = w_r[SIZE_W-1] || (w_r == '0) || h_r[SIZE_W-1] || (h_r == '0);

  assign placed.pos_x  = col_r[COORD_W-1:0];
  assign placed.pos_y  = row_r[COORD_W-1:0];
  assign placed.size_w = w_r[COORD_W-1:0];
  assign placed.size_h = h_r[COORD_W-1:0];
  assign placed.bear_x = left_r;
  assign placed.bear_y = top_r;

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[probe_addr_r] <= tag_wdata;
    end
    tag_q_r <= tag_mem[probe_addr_nxt];
  end

  always_ff @(posedge clk) begin
    if (pay_we) begin
      pay_mem[probe_addr_r] <= pay_wdata;
    end
    pay_q_r <= pay_mem[probe_addr_nxt];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cp_r   <= in_code_point;
      left_r <= in_box_left;
      top_r  <= in_box_top;
      w_r    <= box_w;
      h_r    <= box_h;
    end
    res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= ATLAS_WIDTH_RST;
      height_r <= ATLAS_HEIGHT_RST;
      pad_r    <= PAD_PIXELS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ATLAS_WIDTH:  width_r  <= cfg_data;
        CFG_ATLAS_HEIGHT: height_r <= cfg_data;
        CFG_PAD_PIXELS:   pad_r    <= cfg_data[PAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      probe_addr_r <= '0;
      probe_cnt_r  <= '0;
      col_r        <= SHELF_COL_RST;
      row_r        <= '0;
      tall_r       <= SHELF_TALL_RST;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      probe_addr_r <= probe_addr_nxt;
      probe_cnt_r  <= probe_cnt_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      tall_r       <= tall_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    probe_addr_nxt = probe_addr_r;
    probe_cnt_nxt  = probe_cnt_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    tall_nxt       = tall_r;
    tag_we         = 1'b0;
    tag_wdata      = '0;
    pay_we         = 1'b0;
    pay_wdata      = '0;
    out_valid_nxt  = 1'b0;
    res_nxt        = '0;
    res_nxt.slot   = ENTRY_SLOT_W'(probe_addr_r);
    alu_req        = '0;

    case (state_r)
      ST_CLEAR: begin
        tag_we = 1'b1;
        if (probe_addr_r == SLOT_W'(SLOT_COUNT - 1)) begin
          probe_addr_nxt = '0;
          state_nxt      = ST_IDLE;
        end else begin
          probe_addr_nxt = probe_addr_r + 1'b1;
        end
      end

      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_HASH;
        end
      end

      ST_HASH: begin
        probe_addr_nxt = hash_slot;
        probe_cnt_nxt  = '0;
        state_nxt      = ST_PROBE;
      end

      ST_PROBE: begin
        if (!tag_q_r[TAG_W-1]) begin
          tag_we    = 1'b1;
          tag_wdata = {1'b1, cp_r};
          pay_we    = 1'b1;
          if (box_empty) begin
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            state_nxt = ST_WRAP;
          end
        end else if (tag_q_r[CP_W-1:0] == cp_r) begin
          out_valid_nxt    = 1'b1;
          res_nxt.hit      = 1'b1;
          res_nxt.drawable = (pay_q_r.size_w != '0) && (pay_q_r.size_h != '0);
          res_nxt.ent      = pay_q_r;
          state_nxt        = ST_IDLE;
        end else if (probe_cnt_r == CNT_W'(SLOT_COUNT - 1)) begin
          out_valid_nxt      = 1'b1;
          res_nxt.table_full = 1'b1;
          res_nxt.slot       = '0;
          state_nxt          = ST_IDLE;
        end else begin
          probe_addr_nxt = probe_addr_r + 1'b1;
          probe_cnt_nxt  = probe_cnt_r + 1'b1;
        end
      end

      ST_WRAP: begin
        alu_req.a   = ALU_W'(col_r);
        alu_req.b   = ALU_W'(w_r[COORD_W-1:0]);
        alu_req.c   = ALU_W'(pad_r);
        alu_req.lim = ALU_W'(width_r);
        state_nxt   = alu_rsp.gt ? ST_ROW : ST_FIT;
      end

      ST_ROW: begin
        alu_req.a   = ALU_W'(row_r);
        alu_req.b   = ALU_W'(tall_r);
        alu_req.c   = ALU_W'(pad_r);
        alu_req.lim = ROW_MAX;
        row_nxt     = alu_rsp.gt ? ROW_MAX[ROW_W-1:0] : alu_rsp.sum[ROW_W-1:0];
        col_nxt     = '0;
        tall_nxt    = '0;
        state_nxt   = ST_FIT;
      end

      ST_FIT: begin
        alu_req.a     = ALU_W'(row_r);
        alu_req.b     = ALU_W'(h_r[COORD_W-1:0]);
        alu_req.lim   = ALU_W'(height_r);
        out_valid_nxt = 1'b1;
        if (alu_rsp.gt) begin
          res_nxt.atlas_full = 1'b1;
          state_nxt          = ST_IDLE;
        end else begin
          pay_we           = 1'b1;
          pay_wdata        = placed;
          res_nxt.drawable = 1'b1;
          res_nxt.ent      = placed;
          state_nxt        = ST_COL;
        end
      end

      ST_COL: begin
        alu_req.a = ALU_W'(col_r);
        alu_req.b = ALU_W'(w_r[COORD_W-1:0]);
        alu_req.c = ALU_W'(pad_r);
        col_nxt   = alu_rsp.sum[SIZE_W-1:0];
        state_nxt = ST_TALL;
      end

      ST_TALL: begin
        alu_req.a   = ALU_W'(h_r[COORD_W-1:0]);
        alu_req.lim = ALU_W'(tall_r);
        if (alu_rsp.gt) begin
          tall_nxt = h_r;
        end
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = res_r.hit;
  assign out_drawable     = res_r.drawable;
  assign out_atlas_full   = res_r.atlas_full;
  assign out_table_full   = res_r.table_full;
  assign out_entry_slot   = res_r.slot;
  assign out_atlas_x      = res_r.ent.pos_x;
  assign out_atlas_y      = res_r.ent.pos_y;
  assign out_glyph_width  = res_r.ent.size_w;
  assign out_glyph_height = res_r.ent.size_h;
  assign out_bearing_x    = res_r.ent.bear_x;
  assign out_bearing_y    = res_r.ent.bear_y;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("request taken without going busy");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && (out_table_full || out_atlas_full)))
    else $error("hit reported together with a miss flag");

  a_table_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_table_full) |->
      (out_entry_slot == '0) && !out_drawable && (out_glyph_width == '0))
    else $error("table full result carries data");

  a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PROBE) |-> (probe_cnt_r < CNT_W'(SLOT_COUNT)))
    else $error("probe count past table size");

endmodule

### sim/tb_glyph_cache_shelf_packer_core.sv
`timescale 1ns / 1ps

module tb_glyph_cache_shelf_packer_core;
  import gcsp_pkg::*;

  localparam int SLOTS           = SLOT_COUNT_DEF;
  localparam int CP_MAX          = 1114111;
  localparam int ROW_CAP         = 16383;
  localparam int SETTLE_CYCLES   = 8;
  localparam int WATCHDOG_CYCLES = 4 * (SLOTS + 64);

  typedef struct packed {
    logic [CP_W-1:0]    cp;
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] bottom;
  } glyph_req_t;

  logic                      clk            = 1'b0;
  logic                      rst_n          = 1'b0;
  logic                      start          = 1'b0;
  logic                      busy;
  logic [CP_W-1:0]           in_code_point  = '0;
  logic signed [COORD_W-1:0] in_box_left    = '0;
  logic signed [COORD_W-1:0] in_box_top     = '0;
  logic signed [COORD_W-1:0] in_box_right   = '0;
  logic signed [COORD_W-1:0] in_box_bottom  = '0;
  logic                      cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index      = '0;
  logic [CFG_DATA_W-1:0]     cfg_data       = '0;
  logic                      out_valid;
  logic                      out_hit;
  logic                      out_drawable;
  logic                      out_atlas_full;
  logic                      out_table_full;
  logic [ENTRY_SLOT_W-1:0]   out_entry_slot;
  logic [COORD_W-1:0]        out_atlas_x;
  logic [COORD_W-1:0]        out_atlas_y;
  logic [COORD_W-1:0]        out_glyph_width;
  logic [COORD_W-1:0]        out_glyph_height;
  logic signed [COORD_W-1:0] out_bearing_x;
  logic signed [COORD_W-1:0] out_bearing_y;

  glyph_req_t      glyph_req_q[$];
  result_t         placement_q[$];
  logic [CP_W-1:0] cp_history[$];
  bit              issued_cp[int];

  bit              slot_taken[SLOTS];
  logic [CP_W-1:0] slot_cp[SLOTS];
  entry_t          slot_ent[SLOTS];
  int shelf_col    = int'(SHELF_COL_RST);
  int shelf_row    = 0;
  int shelf_tall   = int'(SHELF_TALL_RST);
  int atlas_w      = int'(ATLAS_WIDTH_RST);
  int atlas_h      = int'(ATLAS_HEIGHT_RST);
  int pad_px       = int'(PAD_PIXELS_RST);

  int gap_pct      = 0;
  int gap_left     = 0;
  int quiet_cycles = 0;
  int mismatches   = 0;

  glyph_cache_shelf_packer_core #(
    .SLOT_COUNT(SLOTS)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_code_point   (in_code_point),
    .in_box_left     (in_box_left),
    .in_box_top      (in_box_top),
    .in_box_right    (in_box_right),
    .in_box_bottom   (in_box_bottom),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_hit         (out_hit),
    .out_drawable    (out_drawable),
    .out_atlas_full  (out_atlas_full),
    .out_table_full  (out_table_full),
    .out_entry_slot  (out_entry_slot),
    .out_atlas_x     (out_atlas_x),
    .out_atlas_y     (out_atlas_y),
    .out_glyph_width (out_glyph_width),
    .out_glyph_height(out_glyph_height),
    .out_bearing_x   (out_bearing_x),
    .out_bearing_y   (out_bearing_y)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int slot_of(input logic [CP_W-1:0] cp);
    logic [63:0] prod;
    prod = 64'(cp) * 64'd2654435761;
    prod = prod ^ (prod >> HASH_SHIFT);
    return int'(prod & 64'(SLOTS - 1));
  endfunction

  function automatic result_t place_glyph(input glyph_req_t rq);
    result_t res;
    entry_t  ent;
    int      idx, n, lft, tp, w, h, wrap_row;
    bit      done, free_at;
    res     = '0;
    ent     = '0;
    idx     = slot_of(rq.cp);
    done    = 1'b0;
    free_at = 1'b0;
    for (n = 0; n < SLOTS && !done; n++) begin
      if (!slot_taken[idx]) begin
        done    = 1'b1;
        free_at = 1'b1;
      end else if (slot_cp[idx] == rq.cp) begin
        done = 1'b1;
      end else begin
        idx = (idx + 1) % SLOTS;
      end
    end
    if (!done) begin
      res.table_full = 1'b1;
      return res;
    end
    res.slot = ENTRY_SLOT_W'(idx);
    if (!free_at) begin
      res.hit      = 1'b1;
      res.ent      = slot_ent[idx];
      res.drawable = (res.ent.size_w != '0) && (res.ent.size_h != '0);
      return res;
    end
    slot_taken[idx] = 1'b1;
    slot_cp[idx]    = rq.cp;
    slot_ent[idx]   = '0;
    lft = $signed(rq.left);
    tp  = $signed(rq.top);
    w   = int'($signed(rq.right)) - lft;
    h   = int'($signed(rq.bottom)) - tp;
    if (w <= 0 || h <= 0) return res;
    if (shelf_col + w + pad_px > atlas_w) begin
      wrap_row   = shelf_row + shelf_tall + pad_px;
      shelf_col  = 0;
      shelf_row  = (wrap_row > ROW_CAP) ? ROW_CAP : wrap_row;
      shelf_tall = 0;
    end
    if (shelf_row + h > atlas_h) begin
      res.atlas_full = 1'b1;
      return res;
    end
    ent.pos_x     = COORD_W'(shelf_col);
    ent.pos_y     = COORD_W'(shelf_row);
    ent.size_w    = COORD_W'(w);
    ent.size_h    = COORD_W'(h);
    ent.bear_x    = rq.left;
    ent.bear_y    = rq.top;
    slot_ent[idx] = ent;
    shelf_col     = (shelf_col + w + pad_px) & 'h1FFF;
    if (h > shelf_tall) shelf_tall = h;
    res.ent      = ent;
    res.drawable = (ent.size_w != '0) && (ent.size_h != '0);
    return res;
  endfunction

  function automatic glyph_req_t random_glyph(input bit fresh_only);
    glyph_req_t rq;
    int         pick, wmax, hmax, lft, tp, w, h;
    wmax = atlas_w / 8;
    wmax = (wmax < 2) ? 2 : (wmax > 48) ? 48 : wmax;
    hmax = atlas_h / 8;
    hmax = (hmax < 2) ? 2 : (hmax > 48) ? 48 : hmax;
    if (!fresh_only && cp_history.size() > 0 && $urandom_range(0, 99) < 30) begin
      rq.cp = cp_history[$urandom_range(0, cp_history.size() - 1)];
    end else begin
      rq.cp = CP_W'($urandom_range(0, CP_MAX));
      while (fresh_only && issued_cp.exists(int'(rq.cp)))
        rq.cp = CP_W'($urandom_range(0, CP_MAX));
    end
    pick = $urandom_range(0, 99);
    w    = $urandom_range(1, wmax);
    h    = $urandom_range(1, hmax);
    lft  = $urandom_range(0, 128) - 64;
    tp   = $urandom_range(0, 128) - 64;
    if (pick < 8) begin
      if (pick < 4) w = -int'($urandom_range(0, 8));
      else h = -int'($urandom_range(0, 8));
    end else if (pick < 14) begin
      w   = $urandom_range(1, 4095);
      lft = $urandom_range(0, 4095 - w) - 2048;
    end else if (pick < 16) begin
      h  = $urandom_range(1, 4095);
      tp = $urandom_range(0, 4095 - h) - 2048;
    end
    rq.left   = COORD_W'(lft);
    rq.right  = COORD_W'(lft + w);
    rq.top    = COORD_W'(tp);
    rq.bottom = COORD_W'(tp + h);
    if (pick >= 96) begin
      rq.left   = COORD_W'($urandom);
      rq.right  = COORD_W'($urandom);
      rq.top    = COORD_W'($urandom);
      rq.bottom = COORD_W'($urandom);
    end
    return rq;
  endfunction

  function automatic string describe(input result_t r);
    return {$sformatf("hit %0b drawable %0b atlas_full %0b table_full %0b slot %0d ",
                      r.hit, r.drawable, r.atlas_full, r.table_full, r.slot),
            $sformatf("x %0d y %0d w %0d h %0d bx %0d by %0d",
                      r.ent.pos_x, r.ent.pos_y, r.ent.size_w, r.ent.size_h,
                      $signed(r.ent.bear_x), $signed(r.ent.bear_y))};
  endfunction

  task automatic push_glyph(input glyph_req_t rq);
    if (!issued_cp.exists(int'(rq.cp))) begin
      issued_cp[int'(rq.cp)] = 1'b1;
      cp_history.push_back(rq.cp);
    end
    glyph_req_q.push_back(rq);
  endtask

  task automatic push_box(input int cp, input int lft, input int tp, input int rgt,
                          input int btm);
    glyph_req_t rq;
    rq.cp     = CP_W'(cp);
    rq.left   = COORD_W'(lft);
    rq.top    = COORD_W'(tp);
    rq.right  = COORD_W'(rgt);
    rq.bottom = COORD_W'(btm);
    push_glyph(rq);
  endtask

  task automatic drain();
    @(posedge clk);
    #1;
    while (glyph_req_q.size() != 0 || start || busy || placement_q.size() != 0) begin
      @(posedge clk);
      #1;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int w, input int h, input int pad, input int count,
                           input int idle_pct);
    drain();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ATLAS_WIDTH;
    cfg_data  <= CFG_DATA_W'(w);
    @(posedge clk);
    cfg_index <= CFG_ATLAS_HEIGHT;
    cfg_data  <= CFG_DATA_W'(h);
    @(posedge clk);
    cfg_index <= CFG_PAD_PIXELS;
    cfg_data  <= CFG_DATA_W'(pad);
    @(posedge clk);
    cfg_we <= 1'b0;
    #1;
    atlas_w = w;
    atlas_h = h;
    pad_px  = pad;
    gap_pct = idle_pct;
    repeat (count) push_glyph(random_glyph(1'b0));
  endtask

  // hold each request until busy drops; idle only between requests
  always @(posedge clk) begin : drive_requests
    glyph_req_t taken, nxt;
    logic       go;
    if (!rst_n) begin
      start    <= 1'b0;
      gap_left <= 0;
    end else begin
      go = start;
      if (start && !busy) begin
        taken.cp     = in_code_point;
        taken.left   = in_box_left;
        taken.top    = in_box_top;
        taken.right  = in_box_right;
        taken.bottom = in_box_bottom;
        placement_q.push_back(place_glyph(taken));
        go = 1'b0;
      end
      if (!go) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (glyph_req_q.size() > 0) begin
          if ($urandom_range(0, 99) < gap_pct) begin
            gap_left <= $urandom_range(1, 12);
          end else begin
            nxt = glyph_req_q.pop_front();
            in_code_point <= nxt.cp;
            in_box_left   <= nxt.left;
            in_box_top    <= nxt.top;
            in_box_right  <= nxt.right;
            in_box_bottom <= nxt.bottom;
            go = 1'b1;
          end
        end
      end
      start <= go;
    end
  end

  always @(posedge clk) begin : check_results
    result_t got, want;
    if (rst_n && out_valid) begin
      got.hit        = out_hit;
      got.drawable   = out_drawable;
      got.atlas_full = out_atlas_full;
      got.table_full = out_table_full;
      got.slot       = out_entry_slot;
      got.ent.pos_x  = out_atlas_x;
      got.ent.pos_y  = out_atlas_y;
      got.ent.size_w = out_glyph_width;
      got.ent.size_h = out_glyph_height;
      got.ent.bear_x = out_bearing_x;
      got.ent.bear_y = out_bearing_y;
      if (placement_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %s", describe(got));
      end else begin
        want = placement_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch expected: %s", describe(want));
            $display("         actual:   %s", describe(got));
          end
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic [CP_W-1:0] twins[$];
    int              cand;
    for (cand = 1; twins.size() < 2; cand++)
      if (slot_of(CP_W'(cand)) == slot_of('0)) twins.push_back(CP_W'(cand));

    gap_pct = 30;
    push_box(0, 0, 0, 4, 3);
    push_box(0, 0, 0, 4, 3);
    push_box(CP_MAX, -2048, -1, -2044, 2);
    push_box(int'(twins[0]), 0, 0, 2, 2);
    push_box(int'(twins[1]), 1, 1, 3, 4);
    push_box(int'(twins[1]), 0, 0, 0, 0);
    push_box('h0AAAAA, 5, 5, 5, 9);
    push_box('h055555, 0, 3, 4, 1);
    push_box('h100000, 2047, 2047, -2048, -2048);
    push_box(7, 0, -2048, 2, 2047);
    push_box(7, 0, 0, 1, 1);
    push_box(8, -2048, -2, 2047, 2);
    push_box(8, 3, 3, 9, 9);
    push_box(9, 0, 2044, 3, 2047);
    push_box(CP_MAX, 0, 0, 1, 1);
    push_box('h0AAAAA, -3, -3, 3, 3);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    run_phase(1024, 1024, 1, 70, 25);
    run_phase(16, 16, 0, 30, 40);
    run_phase(16, 4096, 15, 25, 0);
    run_phase($urandom_range(16, 4096), $urandom_range(16, 4096), $urandom_range(0, 15),
              60, 20);
    run_phase($urandom_range(16, 4096), $urandom_range(16, 4096), $urandom_range(0, 15),
              60, 50);
    run_phase(4096, 4096, 0, 80, 10);
    run_phase(4096, 4096, 15, 60, 0);

    drain();
    if (mismatches == 0 && placement_q.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

### files.f
src/gcsp_pkg.sv
src/gcsp_hash.sv
src/gcsp_alu.sv
src/glyph_cache_shelf_packer_core.sv
sim/tb_glyph_cache_shelf_packer_core.sv
